// ===== rtl/fgr_pkg.sv =====
// Shared types, constants and the 5x7 font table of the glyph square generator.
`timescale 1ns / 1ps

package fgr_pkg;

    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
    localparam int COORD_W     = 17;
    localparam int CURSOR_W    = 16;
    localparam int SCREEN_W    = 13;
    localparam logic [SCREEN_W-1:0] SCREEN_LIMIT = 13'd4096;
    localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 13'd320;
    localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 13'd240;
    localparam logic signed [COORD_W-1:0] CURSOR_MAX = 17'sd32767;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'd32;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    // Glyph bitmap: row 0 in the top five bits, bit 4 of each row is the left column.
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
        logic [7:0] c;
        logic [GLYPH_BITS-1:0] g;
        c = code;
        if (code >= LOWER_A && code <= LOWER_Z) begin
            c = code - CASE_DELTA;
        end
        unique case (c)
            8'h2D: g = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
            8'h2E: g = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12};
            8'h3A: g = {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0};
            8'h2F: g = {5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd0, 5'd0};
            8'h28: g = {5'd2, 5'd4, 5'd8, 5'd8, 5'd8, 5'd4, 5'd2};
            8'h29: g = {5'd8, 5'd4, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8};
            8'h30: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
            8'h31: g = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
            8'h32: g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
            8'h33: g = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
            8'h34: g = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
            8'h35: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
            8'h36: g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
            8'h37: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
            8'h38: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
            8'h39: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
            8'h41: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            8'h42: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
            8'h43: g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
            8'h44: g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
            8'h45: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
            8'h46: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
            8'h47: g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
            8'h48: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            8'h49: g = {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
            8'h4A: g = {5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12};
            8'h4B: g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
            8'h4C: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
            8'h4D: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
            8'h4E: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
            8'h4F: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            8'h50: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
            8'h51: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
            8'h52: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
            8'h53: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
            8'h54: g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
            8'h55: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            8'h56: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
            8'h57: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
            8'h58: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
            8'h59: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
            8'h5A: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
            default: g = '0;  // space and unknown codes: blank
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/fgr_clip.sv =====
// Screen clip test: is a square of side s at (x, y) wholly on screen.
`timescale 1ns / 1ps

module fgr_clip (
    input  logic signed [fgr_pkg::COORD_W-1:0]  i_x,
    input  logic signed [fgr_pkg::COORD_W-1:0]  i_y,
    input  logic        [3:0]                   i_size,
    input  logic        [fgr_pkg::SCREEN_W-1:0] i_width,
    input  logic        [fgr_pkg::SCREEN_W-1:0] i_height,
    output logic                                o_visible
);

    logic signed [fgr_pkg::COORD_W:0] x_end;
    logic signed [fgr_pkg::COORD_W:0] y_end;
    logic signed [fgr_pkg::COORD_W:0] w_ext;
    logic signed [fgr_pkg::COORD_W:0] h_ext;

    assign x_end = {i_x[fgr_pkg::COORD_W-1], i_x} + $signed({{(fgr_pkg::COORD_W-3){1'b0}}, i_size});
    assign y_end = {i_y[fgr_pkg::COORD_W-1], i_y} + $signed({{(fgr_pkg::COORD_W-3){1'b0}}, i_size});
    assign w_ext = $signed({{(fgr_pkg::COORD_W+1-fgr_pkg::SCREEN_W){1'b0}}, i_width});
    assign h_ext = $signed({{(fgr_pkg::COORD_W+1-fgr_pkg::SCREEN_W){1'b0}}, i_height});

    assign o_visible = !i_x[fgr_pkg::COORD_W-1] && !i_y[fgr_pkg::COORD_W-1]
                       && (x_end <= w_ext) && (y_end <= h_ext);

endmodule

// ===== rtl/font_glyph_rect_generator.sv =====
// Top level: 5x7 font character generator emitting one square per lit glyph pixel.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------------
//   in      | input     | i_in_valid / o_in_ready  | char_code restart start_x row_y color scale
//   out     | output    | o_out_valid / i_out_ready| rect_x rect_y rect_size rect_color last
//   cfg     | input     | i_cfg_we                 | i_cfg_index i_cfg_data
//
// A character is accepted in idle; its 35 glyph bits are then scanned one per cycle,
// unless back-pressure holds the scan, through the shared step adder and clip compare;
// a flush then sends the held square, if any, with last set. Scale zero draws nothing.
// Output back-pressure stalls the scan only when a new visible square meets a full
// output word. Reset is synchronous, active low; it clears the cursor and
// restores the screen to 320 x 240.
`timescale 1ns / 1ps

module font_glyph_rect_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_restart,
    input  logic signed [12:0] i_start_x,
    input  logic signed [12:0] i_row_y,
    input  logic [15:0]        i_color,
    input  logic [3:0]         i_scale,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [11:0]        o_rect_x,
    output logic [11:0]        o_rect_y,
    output logic [3:0]         o_rect_size,
    output logic [15:0]        o_rect_color,
    output logic               o_last
);

    localparam int CW = fgr_pkg::COORD_W;

    fgr_pkg::t_state r_state, n_state;

    logic [fgr_pkg::SCREEN_W-1:0]         r_width, r_height;
    logic signed [fgr_pkg::CURSOR_W-1:0]  r_cursor, n_cursor;
    logic [fgr_pkg::GLYPH_BITS-1:0]       r_bits, n_bits;
    logic [2:0]                           r_col, n_col;
    logic [2:0]                           r_row, n_row;
    logic signed [CW-1:0]                 r_base, n_base;
    logic signed [CW-1:0]                 r_x, n_x;
    logic signed [CW-1:0]                 r_y, n_y;
    logic [3:0]                           r_scale, n_scale;
    logic [15:0]                          r_color, n_color;
    logic                                 r_pend_valid, n_pend_valid;
    logic [11:0]                          r_pend_x, n_pend_x;
    logic [11:0]                          r_pend_y, n_pend_y;
    logic                                 r_out_valid, n_out_valid;
    logic [11:0]                          r_out_x, n_out_x;
    logic [11:0]                          r_out_y, n_out_y;
    logic [3:0]                           r_out_size, n_out_size;
    logic [15:0]                          r_out_color, n_out_color;
    logic                                 r_out_last, n_out_last;

    logic                                 in_accept;
    logic [fgr_pkg::SCREEN_W-1:0]         width_clamp, height_clamp;
    logic                                 visible;
    logic                                 cand;
    logic                                 slot;
    logic signed [fgr_pkg::CURSOR_W-1:0]  cur_load;
    logic signed [CW-1:0]                 cur_next;
    logic [6:0]                           pitch;
    logic signed [CW-1:0]                 step_sum;

    assign in_accept    = i_in_valid && o_in_ready;
    assign o_in_ready   = (r_state == fgr_pkg::ST_IDLE);
    assign width_clamp  = (r_width  > fgr_pkg::SCREEN_LIMIT) ? fgr_pkg::SCREEN_LIMIT : r_width;
    assign height_clamp = (r_height > fgr_pkg::SCREEN_LIMIT) ? fgr_pkg::SCREEN_LIMIT : r_height;

    fgr_clip u_clip (
        .i_x       (r_x),
        .i_y       (r_y),
        .i_size    (r_scale),
        .i_width   (width_clamp),
        .i_height  (height_clamp),
        .o_visible (visible)
    );

    assign cand = r_bits[fgr_pkg::GLYPH_BITS-1] && visible;
    assign slot = !r_out_valid || i_out_ready;

    // Cursor load and advance, computed once at accept.
    assign cur_load = i_restart ? fgr_pkg::CURSOR_W'(i_start_x) : r_cursor;
    assign pitch    = {1'b0, i_scale, 2'b00} + {2'b00, i_scale, 1'b0};
    assign cur_next = CW'(cur_load) + $signed({{(CW-7){1'b0}}, pitch});

    // Shared step adder: next column, or next row when the column wraps.
    assign step_sum = ((r_col == 3'(fgr_pkg::GLYPH_COLS - 1)) ? r_y : r_x)
                      + $signed({{(CW-4){1'b0}}, r_scale});

    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_bits       = r_bits;
        n_col        = r_col;
        n_row        = r_row;
        n_base       = r_base;
        n_x          = r_x;
        n_y          = r_y;
        n_scale      = r_scale;
        n_color      = r_color;
        n_pend_valid = r_pend_valid;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_size   = r_out_size;
        n_out_color  = r_out_color;
        n_out_last   = r_out_last;

        unique case (r_state)
            fgr_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_bits  = fgr_pkg::glyph_bits(i_char_code);
                    n_col   = '0;
                    n_row   = '0;
                    n_base  = CW'(cur_load);
                    n_x     = CW'(cur_load);
                    n_y     = CW'(i_row_y);
                    n_scale = i_scale;
                    n_color = i_color;
                    if (i_scale == 4'd0) begin
                        n_cursor = cur_load;  // no advance
                    end else begin
                        n_cursor = (cur_next > fgr_pkg::CURSOR_MAX)
                                   ? fgr_pkg::CURSOR_W'(fgr_pkg::CURSOR_MAX)
                                   : cur_next[fgr_pkg::CURSOR_W-1:0];
                        n_state  = fgr_pkg::ST_SCAN;
                    end
                end
            end
            fgr_pkg::ST_SCAN: begin
                // Hold when a new square must push the held one into a full output word.
                if (!(cand && r_pend_valid && !slot)) begin
                    if (cand) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_x     = r_pend_x;
                            n_out_y     = r_pend_y;
                            n_out_size  = r_scale;
                            n_out_color = r_color;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_x     = r_x[11:0];
                        n_pend_y     = r_y[11:0];
                    end
                    n_bits = {r_bits[fgr_pkg::GLYPH_BITS-2:0], 1'b0};
                    if (r_col == 3'(fgr_pkg::GLYPH_COLS - 1)) begin
                        n_col = '0;
                        n_row = r_row + 3'd1;
                        n_x   = r_base;
                        n_y   = step_sum;
                        if (r_row == 3'(fgr_pkg::GLYPH_ROWS - 1)) begin
                            n_state = fgr_pkg::ST_FLUSH;
                        end
                    end else begin
                        n_col = r_col + 3'd1;
                        n_x   = step_sum;
                    end
                end
            end
            fgr_pkg::ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = fgr_pkg::ST_IDLE;
                end else if (slot) begin
                    n_out_valid  = 1'b1;
                    n_out_x      = r_pend_x;
                    n_out_y      = r_pend_y;
                    n_out_size   = r_scale;
                    n_out_color  = r_color;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = fgr_pkg::ST_IDLE;
                end
            end
            default: n_state = fgr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fgr_pkg::ST_IDLE;
            r_width      <= fgr_pkg::WIDTH_RESET;
            r_height     <= fgr_pkg::HEIGHT_RESET;
            r_cursor     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cursor     <= n_cursor;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fgr_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                    fgr_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits      <= n_bits;
        r_col       <= n_col;
        r_row       <= n_row;
        r_base      <= n_base;
        r_x         <= n_x;
        r_y         <= n_y;
        r_scale     <= n_scale;
        r_color     <= n_color;
        r_pend_x    <= n_pend_x;
        r_pend_y    <= n_pend_y;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_size  <= n_out_size;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_rect_x     = r_out_x;
    assign o_rect_y     = r_out_y;
    assign o_rect_size  = r_out_size;
    assign o_rect_color = r_out_color;
    assign o_last       = r_out_last;

    // A held square never survives into idle: the flush must have sent it.
    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fgr_pkg::ST_IDLE) |-> !r_pend_valid)
        else $error("held square left behind in idle");

    // Scale zero draws nothing and keeps the block idle.
    a_scale_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_scale == 4'd0)) |=> (r_state == fgr_pkg::ST_IDLE))
        else $error("scale zero started a scan");

    // Every emitted square has a nonzero side.
    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rect_size != 4'd0))
        else $error("square of size zero emitted");

endmodule
